### rtl/mth_pkg.sv
// Shared types and constants for the magnetometer true heading block.
// Holds the CORDIC cell payload type, the arctangent table and register indexes.
// No dependencies.
package mth_pkg;

	localparam int CORDIC_STAGES_DEF = 16;
	localparam int ATAN_LEN = 24;

	// Datapath width of the rotating vector: the calibrated axis is 33 bit signed,
	// negation and CORDIC growth stay below 2^35 in magnitude.
	localparam int XW = 37;
	localparam int PW = 33;

	localparam logic [31:0] ATAN_BAM [ATAN_LEN] = '{
		32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
		32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
		32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722,
		32'd20861, 32'd10430, 32'd5215, 32'd2608, 32'd1304,
		32'd652, 32'd326, 32'd163, 32'd81
	};

	localparam logic [31:0] HALF_TURN = 32'h8000_0000;
	localparam logic [31:0] ROUND_HALF = 32'h0000_8000;

	localparam logic [2:0] REG_OFFSET_X = 3'd0;
	localparam logic [2:0] REG_OFFSET_Y = 3'd1;
	localparam logic [2:0] REG_SCALE_X = 3'd2;
	localparam logic [2:0] REG_SCALE_Y = 3'd3;
	localparam logic [2:0] REG_DECLINATION = 3'd4;

	localparam logic [15:0] SCALE_ONE = 16'd4096;

	typedef struct packed {
		logic zero;
		logic signed [XW-1:0] x;
		logic signed [XW-1:0] y;
		logic [31:0] ang;
	} cell_t;

endpackage

### rtl/mth_front.sv
// Calibration front end: hard-iron subtract, soft-iron multiply, half-plane fold.
// Three pipeline stages feeding the first CORDIC cell. Depends on mth_pkg.
module mth_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 in_valid,
	input  logic signed [15:0]   raw_x,
	input  logic signed [15:0]   raw_y,
	input  logic signed [15:0]   offset_x,
	input  logic signed [15:0]   offset_y,
	input  logic [15:0]          scale_x,
	input  logic [15:0]          scale_y,
	output logic                 out_valid,
	output mth_pkg::cell_t       out
);
	import mth_pkg::*;

	logic v_s1, v_s2, v_s3;
	logic signed [16:0] cx_s1, cy_s1;
	logic signed [PW-1:0] vx_s2, vy_s2;
	cell_t pre_s3;

	logic signed [33:0] px, py;
	logic signed [XW-1:0] xe, ye;
	logic neg;

	always_comb begin
		px = cx_s1 * $signed({1'b0, scale_x});
		py = cy_s1 * $signed({1'b0, scale_y});
		xe = XW'(vx_s2);
		ye = XW'(vy_s2);
		neg = vx_s2[PW-1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cx_s1 <= 17'(raw_x) - 17'(offset_x);
			cy_s1 <= 17'(raw_y) - 17'(offset_y);
			vx_s2 <= px[PW-1:0];
			vy_s2 <= py[PW-1:0];
			// fold the left half plane over and start from half a turn
			pre_s3.zero <= (vx_s2 == '0) && (vy_s2 == '0);
			pre_s3.x <= neg ? -xe : xe;
			pre_s3.y <= neg ? -ye : ye;
			pre_s3.ang <= neg ? HALF_TURN : '0;
		end
	end

	assign out_valid = v_s3;
	assign out = pre_s3;

endmodule

### rtl/mth_cordic_cell.sv
// One vectoring CORDIC cell: rotates toward the X axis by atan(2^-SHIFT).
// Registers its result and hands it to the next cell. Depends on mth_pkg.
module mth_cordic_cell #(
	parameter int SHIFT = 0
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            in_valid,
	input  mth_pkg::cell_t  in,
	output logic            out_valid,
	output mth_pkg::cell_t  out
);
	import mth_pkg::*;

	logic signed [XW-1:0] sx, sy;
	cell_t nxt;
	logic v_q;
	cell_t d_q;

	always_comb begin
		sx = in.x >>> SHIFT;
		sy = in.y >>> SHIFT;
		nxt = in;
		// a zero vector passes untouched so its angle stays zero
		if (!in.zero) begin
			if (!in.y[XW-1]) begin
				nxt.x = in.x + sy;
				nxt.y = in.y - sx;
				nxt.ang = in.ang + ATAN_BAM[SHIFT];
			end else begin
				nxt.x = in.x - sy;
				nxt.y = in.y + sx;
				nxt.ang = in.ang - ATAN_BAM[SHIFT];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (en) begin
			v_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_q <= nxt;
		end
	end

	assign out_valid = v_q;
	assign out = d_q;

endmodule

### rtl/magnetometer_true_heading.sv
// Magnetometer true heading: calibrated atan2 compass heading with declination.
//
// Input stream s_*: one raw sample per beat, s_tdata = {raw_y, raw_x}.
// Output stream m_*: one heading per beat, m_tdata = heading, 65536 per turn.
// Config channel cfg_*: cfg_index selects offset_x, offset_y, scale_x, scale_y
// or declination; cfg_data is written when cfg_valid is high (cfg_ready is
// always high). Unknown indexes are ignored. Write only while the pipe is empty.
//
// Pipeline from input beat to output beat: three calibration stages, one CORDIC
// cell per stage (CORDIC_STAGES, capped at ATAN_LEN), one output register. One
// sample per cycle unless the receiver stalls; all cells move in lock step.
//
// Reset clears all stage valid bits and loads offsets 0, scales 1.0 (4096),
// declination 0. When the receiver stalls, the whole chain holds and s_tready
// drops once the output register is full and not being taken.
// Depends on mth_pkg, mth_front and mth_cordic_cell.
module magnetometer_true_heading #(
	parameter int CORDIC_STAGES = mth_pkg::CORDIC_STAGES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [15:0] raw_x, [31:16] raw_y
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [15:0] heading
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data
);
	import mth_pkg::*;

	localparam int NSTG = (CORDIC_STAGES < ATAN_LEN) ? CORDIC_STAGES : ATAN_LEN;

	logic signed [15:0] offset_x_q, offset_y_q, declination_q;
	logic [15:0] scale_x_q, scale_y_q;

	logic adv;
	logic [NSTG:0] vld;
	cell_t pl [NSTG+1];

	logic m_tvalid_q;
	logic [15:0] heading_q;
	logic [31:0] rnd;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_x_q <= '0;
			offset_y_q <= '0;
			scale_x_q <= SCALE_ONE;
			scale_y_q <= SCALE_ONE;
			declination_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_OFFSET_X: offset_x_q <= cfg_data;
				REG_OFFSET_Y: offset_y_q <= cfg_data;
				REG_SCALE_X: scale_x_q <= cfg_data;
				REG_SCALE_Y: scale_y_q <= cfg_data;
				REG_DECLINATION: declination_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// advance the whole chain whenever the output register can take a beat
	assign adv = !m_tvalid_q || m_tready;
	assign s_tready = adv;

	mth_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (s_tvalid),
		.raw_x     (s_tdata[15:0]),
		.raw_y     (s_tdata[31:16]),
		.offset_x  (offset_x_q),
		.offset_y  (offset_y_q),
		.scale_x   (scale_x_q),
		.scale_y   (scale_y_q),
		.out_valid (vld[0]),
		.out       (pl[0])
	);

	for (genvar i = 0; i < NSTG; i++) begin : g_cell
		mth_cordic_cell #(.SHIFT(i)) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (adv),
			.in_valid  (vld[i]),
			.in        (pl[i]),
			.out_valid (vld[i+1]),
			.out       (pl[i+1])
		);
	end

	assign rnd = pl[NSTG].ang + ROUND_HALF;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (adv) begin
			m_tvalid_q <= vld[NSTG];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			heading_q <= rnd[31:16] + declination_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata = heading_q;

	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> u_front.v_s1)
		else $error("accepted beat did not enter the first stage");

	a_zero_angle: assert property (@(posedge clk) disable iff (!arst_n)
		(vld[NSTG] && pl[NSTG].zero) |-> (pl[NSTG].ang == '0))
		else $error("zero vector left the chain with a nonzero angle");

	a_tail_held: assert property (@(posedge clk) disable iff (!arst_n)
		(vld[NSTG] && !adv) |=> vld[NSTG])
		else $error("last cell lost a beat during a stall");

	a_out_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		(vld[NSTG] && adv) |=> m_tvalid)
		else $error("finished beat did not reach the output register");

endmodule
